### rtl/crf_pkg.sv
// shared constants and types for the chunked frame reassembler
package crf_pkg;

  // field widths of the item channels
  localparam int FUNC_W   = 2;
  localparam int FRAME_W  = 32;
  localparam int HALF_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int RADDR_W  = 15;
  localparam int RLEN_W   = 15;

  // defaults for the top level parameters
  localparam int BUFFER_BYTES_DEF = 20480;
  localparam int MAX_CHUNKS_DEF   = 32;

  // fixed values
  localparam logic [HALF_W-1:0]  STRIDE_RESET   = 16'd1400;
  localparam logic [FRAME_W-1:0] FRAME_ID_RESET = 32'hFFFF_FFFF;
  localparam logic [HALF_W-1:0]  HEADER_BYTES   = 16'd8;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_HEADER  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PAYLOAD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

  // header status codes
  typedef enum logic [STATUS_W-1:0] {
    HS_SHORT     = 2'd0,
    HS_ACCEPTED  = 2'd1,
    HS_DUPLICATE = 2'd2,
    HS_RANGE     = 2'd3
  } status_t;

endpackage

### rtl/crf_ram.sv
// generic single write, single read ram with registered read data
module crf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/chunked_frame_reassembler.sv
// chunked frame reassembler: chunk bookkeeping and ping-pong byte store
// an accepted item's result is registered in the output register
// throughput: one item per cycle; only a stalled, unaccepted result holds the input
// the store ram has one write and one read port; a read item's byte leaves the ram
// register in the cycle its result is shown
// reset: synchronous active low, clears all bookkeeping; the byte store is not cleared
module chunked_frame_reassembler #(
  parameter int BUFFER_BYTES = crf_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_CHUNKS   = crf_pkg::MAX_CHUNKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [crf_pkg::HALF_W-1:0]    cfg_chunk_stride,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [crf_pkg::FUNC_W-1:0]    in_func,
  input  logic [crf_pkg::FRAME_W-1:0]   in_frame_id,
  input  logic [crf_pkg::HALF_W-1:0]    in_chunk_index,
  input  logic [crf_pkg::HALF_W-1:0]    in_total_chunks,
  input  logic [crf_pkg::HALF_W-1:0]    in_packet_length,
  input  logic [crf_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          in_decoder_busy,
  input  logic                          in_read_buffer,
  input  logic [crf_pkg::RADDR_W-1:0]   in_read_address,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [crf_pkg::STATUS_W-1:0]  out_header_status,
  output logic                          out_frame_ready,
  output logic                          out_ready_buffer,
  output logic [crf_pkg::RLEN_W-1:0]    out_ready_length,
  output logic [crf_pkg::BYTE_W-1:0]    out_read_data
);

  import crf_pkg::*;

  localparam int CIW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CW  = $clog2(MAX_CHUNKS + 1);
  localparam int PW  = CIW + HALF_W;
  localparam int SW  = PW + 1;
  localparam int LW  = $clog2(BUFFER_BYTES + 1);
  localparam int RD  = 2 * BUFFER_BYTES;
  localparam int RAW = $clog2(RD);
  localparam logic [SW-1:0]  BUF_LIM_S = SW'(BUFFER_BYTES);
  localparam logic [LW-1:0]  BUF_LIM_L = LW'(BUFFER_BYTES);
  localparam logic [RAW-1:0] HALF_BASE = RAW'(BUFFER_BYTES);

  // bookkeeping registers
  logic [HALF_W-1:0]     stride_r;
  logic [FRAME_W-1:0]    cur_frame_r, cur_frame_nxt;
  logic [CW-1:0]         rcv_count_r, rcv_count_nxt;
  logic [MAX_CHUNKS-1:0] seen_mask_r, seen_mask_nxt;
  logic [LW-1:0]         last_len_r, last_len_nxt;
  logic                  active_half_r, active_half_nxt;
  logic [LW-1:0]         pend_offset_r, pend_offset_nxt;
  logic [HALF_W-1:0]     pend_remain_r, pend_remain_nxt;
  logic [HALF_W-1:0]     pend_total_r, pend_total_nxt;
  logic                  pend_valid_r, pend_valid_nxt;

  // output register
  logic                out_valid_r;
  status_t             status_r, status_nxt;
  logic                frame_ready_r, frame_ready_nxt;
  logic                ready_buf_r, ready_buf_nxt;
  logic [LW-1:0]       ready_len_r, ready_len_nxt;
  logic                rd_sel_r, rd_sel_nxt;

  // store ram signals
  logic                ram_we;
  logic [RAW-1:0]      ram_waddr;
  logic                ram_re;
  logic [RAW-1:0]      ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  // header datapath
  logic                accept;
  logic [HALF_W-1:0]   pay_bytes;
  logic [CIW-1:0]      idx;
  logic [PW-1:0]       offset_prod;
  logic [SW-1:0]       end_sum;
  logic                in_range;
  logic                commit;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  assign pay_bytes   = in_packet_length - HEADER_BYTES;
  assign idx         = in_chunk_index[CIW-1:0];
  assign offset_prod = PW'(idx) * PW'(stride_r);
  assign end_sum     = SW'(offset_prod) + SW'(pay_bytes);
  assign in_range    = (in_chunk_index < HALF_W'(MAX_CHUNKS)) && (end_sum <= BUF_LIM_S);

  // store access: payload writes at the pending offset, reads by address
  assign ram_we    = accept && (in_func == FUNC_PAYLOAD) && pend_valid_r
                     && (pend_remain_r != '0) && (pend_offset_r < BUF_LIM_L);
  assign ram_waddr = RAW'(pend_offset_r) + (active_half_r ? HALF_BASE : '0);
  assign ram_re    = accept && (in_func == FUNC_READ)
                     && (LW'(in_read_address) < BUF_LIM_L);
  assign ram_raddr = RAW'(in_read_address) + (in_read_buffer ? HALF_BASE : '0);

  crf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state and result for the item on the input
  always_comb begin
    cur_frame_nxt   = cur_frame_r;
    rcv_count_nxt   = rcv_count_r;
    seen_mask_nxt   = seen_mask_r;
    last_len_nxt    = last_len_r;
    active_half_nxt = active_half_r;
    pend_offset_nxt = pend_offset_r;
    pend_remain_nxt = pend_remain_r;
    pend_total_nxt  = pend_total_r;
    pend_valid_nxt  = pend_valid_r;
    status_nxt      = HS_SHORT;
    frame_ready_nxt = 1'b0;
    ready_buf_nxt   = 1'b0;
    ready_len_nxt   = '0;
    rd_sel_nxt      = 1'b0;
    commit          = 1'b0;

    unique case (in_func)
      FUNC_HEADER: begin
        pend_valid_nxt = 1'b0;
        if (in_packet_length >= HEADER_BYTES) begin
          // a new frame id restarts the bookkeeping
          if (in_frame_id != cur_frame_r) begin
            cur_frame_nxt = in_frame_id;
            rcv_count_nxt = '0;
            seen_mask_nxt = '0;
          end
          if (!in_range) begin
            status_nxt = HS_RANGE;
          end else if (seen_mask_nxt[idx]) begin
            status_nxt = HS_DUPLICATE;
          end else begin
            status_nxt         = HS_ACCEPTED;
            seen_mask_nxt[idx] = 1'b1;
            rcv_count_nxt      = rcv_count_nxt + CW'(1);
            if (in_chunk_index + HALF_W'(1) == in_total_chunks) begin
              last_len_nxt = LW'(end_sum);
            end
            pend_offset_nxt = LW'(offset_prod);
            pend_remain_nxt = pay_bytes;
            pend_total_nxt  = in_total_chunks;
            if (pay_bytes == '0) begin
              commit = 1'b1;
            end else begin
              pend_valid_nxt = 1'b1;
            end
          end
        end
      end
      FUNC_PAYLOAD: begin
        if (ram_we) begin
          pend_offset_nxt = pend_offset_r + LW'(1);
          pend_remain_nxt = pend_remain_r - HALF_W'(1);
          if (pend_remain_r == HALF_W'(1)) begin
            pend_valid_nxt = 1'b0;
            commit         = 1'b1;
          end
        end else begin
          pend_valid_nxt = 1'b0;
        end
      end
      FUNC_READ: begin
        rd_sel_nxt = ram_re;
      end
      default: begin
      end
    endcase

    // frame complete: hand over unless the decoder is busy; the count and mask clear either way
    if (commit && (HALF_W'(rcv_count_nxt) == pend_total_nxt)) begin
      if (!in_decoder_busy) begin
        frame_ready_nxt = 1'b1;
        ready_buf_nxt   = active_half_r;
        ready_len_nxt   = last_len_nxt;
        active_half_nxt = !active_half_r;
      end
      rcv_count_nxt = '0;
      seen_mask_nxt = '0;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= STRIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stride_r <= cfg_chunk_stride;
    end
  end

  // bookkeeping update on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_frame_r   <= FRAME_ID_RESET;
      rcv_count_r   <= '0;
      seen_mask_r   <= '0;
      last_len_r    <= '0;
      active_half_r <= 1'b0;
      pend_offset_r <= '0;
      pend_remain_r <= '0;
      pend_total_r  <= '0;
      pend_valid_r  <= 1'b0;
    end else if (accept) begin
      cur_frame_r   <= cur_frame_nxt;
      rcv_count_r   <= rcv_count_nxt;
      seen_mask_r   <= seen_mask_nxt;
      last_len_r    <= last_len_nxt;
      active_half_r <= active_half_nxt;
      pend_offset_r <= pend_offset_nxt;
      pend_remain_r <= pend_remain_nxt;
      pend_total_r  <= pend_total_nxt;
      pend_valid_r  <= pend_valid_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      frame_ready_r <= frame_ready_nxt;
      ready_buf_r   <= ready_buf_nxt;
      ready_len_r   <= ready_len_nxt;
      rd_sel_r      <= rd_sel_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_header_status = status_r;
  assign out_frame_ready   = frame_ready_r;
  assign out_ready_buffer  = ready_buf_r;
  assign out_ready_length  = RLEN_W'(ready_len_r);
  assign out_read_data     = rd_sel_r ? ram_rdata : '0;

`ifndef ASSERT_OFF
  // every accepted item shows a result in the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  // an armed payload window always has bytes left
  a_pending_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_remain_r != '0))
    else $error("payload window armed with nothing remaining");

  // received count matches the bits set in the seen mask
  a_count_mask: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(seen_mask_r) == int'(rcv_count_r))
    else $error("received count disagrees with seen mask");

  // the active half flips only with a frame handover
  a_flip_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (active_half_nxt != active_half_r)) |=> (out_valid_r && frame_ready_r))
    else $error("active half flipped without frame ready");

  // a handed over frame never carries read data
  a_ready_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_ready_r) |-> !rd_sel_r)
    else $error("frame ready on a read result");
`endif

endmodule
